@@ sv/positional_sequence_store_core_assert.svh @@
// Assertion macros for the positional sequence store.
// Every use expects signals named clk and rst_n in the enclosing module.
`ifndef POSITIONAL_SEQUENCE_STORE_CORE_ASSERT_SVH
`define POSITIONAL_SEQUENCE_STORE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pss: same-cycle check failed");

// Next-cycle implication.
`define PSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pss: next-cycle check failed");

`else

`define PSS_ASSERT_IMP(lbl, ante, cons)
`define PSS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ sv/pss_pkg.sv @@
package pss_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 5;
  localparam int VAL_W = 32;
  localparam int POS_W = 8;
  localparam int CMD_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_END   = 3'd1,
    CMD_INS_POS   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_END   = 3'd4,
    CMD_DEL_POS   = 3'd5,
    CMD_READ_ALL  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic exec_edit;   // apply the change request on the input ports
    logic emit_empty;  // load the empty-readout result
    logic ptr_clr;     // restart the readout pointer
    logic emit_entry;  // load the entry under the pointer, advance it
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic count_zero;
    logic rd_last;     // pointer sits on the final entry
  } sts_t;

endpackage

@@ sv/pss_ctrl.sv @@
`include "positional_sequence_store_core_assert.svh"

module pss_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [pss_pkg::CMD_W-1:0] in_cmd,
  input  pss_pkg::sts_t           sts,
  output logic                    in_ready,
  output pss_pkg::ctl_t           ctl
);
  import pss_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    ctl       = '0;
    accept    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = sts.out_free;
        accept   = in_valid && sts.out_free;
        if (accept) begin
          case (cmd_t'(in_cmd))
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_POS,
            CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_POS: begin
              ctl.exec_edit = 1'b1;
            end
            CMD_READ_ALL: begin
              if (sts.count_zero) begin
                ctl.emit_empty = 1'b1;
              end else begin
                ctl.ptr_clr = 1'b1;
                state_nxt   = S_READ;
              end
            end
            default: begin
              // unused code: dropped without a result
            end
          endcase
        end
      end
      S_READ: begin
        if (sts.out_free) begin
          ctl.emit_entry = 1'b1;
          if (sts.rd_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  `PSS_ASSERT_NXT(a_read_starts, accept && (in_cmd == CMD_READ_ALL) && !sts.count_zero, state_r == S_READ)
  `PSS_ASSERT_NXT(a_read_ends, (state_r == S_READ) && sts.out_free && sts.rd_last, state_r == S_IDLE)
  `PSS_ASSERT_IMP(a_read_nonempty, state_r == S_READ, !sts.count_zero)

endmodule

@@ sv/pss_dp.sv @@
`include "positional_sequence_store_core_assert.svh"

module pss_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pss_pkg::ctl_t                     ctl,
  input  logic [pss_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [pss_pkg::VAL_W-1:0]  in_value,
  input  logic [pss_pkg::POS_W-1:0]         in_position,
  input  logic                              out_ready,
  output pss_pkg::sts_t                     sts,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic signed [pss_pkg::VAL_W-1:0]  out_read_value,
  output logic [pss_pkg::CNT_W-1:0]         out_count_now,
  output logic                              out_last
);
  import pss_pkg::*;

  // cell chain, front at index 0; contents undefined until written
  logic signed [VAL_W-1:0] cells_r [DEPTH];
  logic signed [VAL_W-1:0] cells_nxt [DEPTH];
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [IDX_W-1:0]        ptr_r, ptr_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic signed [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    full, empty;
  logic [POS_W:0]          pos_w, cnt_w;
  logic                    pos_ins_ok, pos_del_ok;
  logic                    do_ins, do_del;
  logic [POS_W-1:0]        idx;
  status_t                 edit_st;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign pos_w = {1'b0, in_position};
  assign cnt_w = (POS_W+1)'(count_r);
  assign pos_ins_ok = (in_position != '0) && (pos_w <= cnt_w + 1'b1);
  assign pos_del_ok = (in_position != '0) && (pos_w <= cnt_w);

  // legality, status and slot index of a change request
  always_comb begin
    do_ins  = 1'b0;
    do_del  = 1'b0;
    idx     = '0;
    edit_st = ST_OK;
    case (cmd_t'(in_cmd))
      CMD_INS_FRONT: begin
        if (full) edit_st = ST_FULL;
        else do_ins = 1'b1;
      end
      CMD_INS_END: begin
        idx = POS_W'(count_r);
        if (full) edit_st = ST_FULL;
        else do_ins = 1'b1;
      end
      CMD_INS_POS: begin
        idx = in_position - 1'b1;
        if (!pos_ins_ok) edit_st = ST_BADPOS;
        else if (full) edit_st = ST_FULL;
        else do_ins = 1'b1;
      end
      CMD_DEL_FRONT: begin
        if (empty) edit_st = ST_EMPTY;
        else do_del = 1'b1;
      end
      CMD_DEL_END: begin
        idx = POS_W'(count_r) - 1'b1;
        if (empty) edit_st = ST_EMPTY;
        else do_del = 1'b1;
      end
      CMD_DEL_POS: begin
        idx = in_position - 1'b1;
        if (empty) edit_st = ST_EMPTY;
        else if (!pos_del_ok) edit_st = ST_BADPOS;
        else do_del = 1'b1;
      end
      default: begin
        edit_st = ST_OK;
      end
    endcase
    if (!ctl.exec_edit) begin
      do_ins = 1'b0;
      do_del = 1'b0;
    end
  end

  // each cell picks its neighbour, the new value or itself
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_nxt[i] = cells_r[i];
      if (do_ins) begin
        if (POS_W'(i) > idx) cells_nxt[i] = cells_r[(i == 0) ? 0 : i - 1];
        else if (POS_W'(i) == idx) cells_nxt[i] = in_value;
      end else if (do_del) begin
        if (POS_W'(i) >= idx) cells_nxt[i] = cells_r[(i == DEPTH - 1) ? i : i + 1];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + 1'b1;
    else if (do_del) count_nxt = count_r - 1'b1;
  end

  always_comb begin
    ptr_nxt = ptr_r;
    if (ctl.ptr_clr) ptr_nxt = '0;
    else if (ctl.emit_entry) ptr_nxt = ptr_r + 1'b1;
  end

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.count_zero = empty;
  assign sts.rd_last    = (CNT_W'(ptr_r) + 1'b1 == count_r);

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;
    if (ctl.exec_edit) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = edit_st;
      out_value_nxt  = '0;
      out_count_nxt  = count_nxt;
      out_last_nxt   = 1'b1;
    end else if (ctl.emit_empty) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_EMPTY;
      out_value_nxt  = '0;
      out_count_nxt  = '0;
      out_last_nxt   = 1'b1;
    end else if (ctl.emit_entry) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_OK;
      out_value_nxt  = cells_r[ptr_r];
      out_count_nxt  = count_r;
      out_last_nxt   = sts.rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      cells_r[i] <= cells_nxt[i];
    end
    ptr_r        <= ptr_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_value_r;
  assign out_count_now  = out_count_r;
  assign out_last       = out_last_r;

  `PSS_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `PSS_ASSERT_NXT(a_count_held, !ctl.exec_edit, $stable(count_r))
  `PSS_ASSERT_NXT(a_ptr_steps, ctl.emit_entry && !sts.rd_last, ptr_r == $past(ptr_r) + 1'b1)

endmodule

@@ sv/positional_sequence_store_core.sv @@
// Positional sequence store: an ordered list of up to pss_pkg::DEPTH (16) signed
// 32-bit values held in a chain of registers, front first. Each request on the
// in_ channel inserts at the front, the end or a 1-based position, deletes the
// front, end or positional entry, or reads the whole list out. A change request
// gives one result (status ok / full / empty / bad position, count_now after the
// change, last set): every cell picks its neighbour, the new
// value or itself at once, and the result goes straight into the output
// register, so change requests flow one per cycle while out_ready is high. A
// readout gives one result per entry, front first, with last on the final one,
// one per cycle while out_ready is high, from a single read pointer; an empty
// list reads out as a single result with status empty. During a readout no new
// request is taken. Command code 7 is taken and dropped with no result. There
// is no clearing pass after reset: the count clears at once, and cells are
// only read below it.
module positional_sequence_store_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pss_pkg::CMD_W-1:0]         in_cmd,
  input  logic signed [pss_pkg::VAL_W-1:0]  in_value,
  input  logic [pss_pkg::POS_W-1:0]         in_position,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_status,
  output logic signed [pss_pkg::VAL_W-1:0]  out_read_value,
  output logic [pss_pkg::CNT_W-1:0]         out_count_now,
  output logic                              out_last
);
  import pss_pkg::*;

  ctl_t ctl;
  sts_t sts;

  // sequencing: accepts requests, steps through readouts
  pss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .sts      (sts),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // cell chain, count, read pointer and output register
  pss_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_ready      (out_ready),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count_now  (out_count_now),
    .out_last       (out_last)
  );

endmodule

@@ dv/tb_positional_sequence_store_core.sv @@
module tb_positional_sequence_store_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  // Code 7 is outside cmd_t: the block takes it and drops it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  // Cycles with no handshake on either side before the run is abandoned.
  // This is far above the longest gap that random pacing produces.
  localparam int WATCHDOG_LIMIT = 3000;
  // Settling time after the last request. It covers a full readout
  // and also the case where the last request produced no result.
  localparam int SETTLE_CYCLES = 24;

  typedef enum int {PACE_FLOW, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pacing_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VAL_W-1:0]   read_value;
    logic [CNT_W-1:0]          count_now;
    logic                      last;
  } list_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [CMD_W-1:0]          in_cmd;
  logic signed [VAL_W-1:0]   in_value;
  logic [POS_W-1:0]          in_position;
  logic                      out_valid;
  logic                      out_ready;
  logic [1:0]                out_status;
  logic signed [VAL_W-1:0]   out_read_value;
  logic [CNT_W-1:0]          out_count_now;
  logic                      out_last;

  positional_sequence_store_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_value       (in_value),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count_now  (out_count_now),
    .out_last       (out_last)
  );

  // Shadow copy of the list, front at index 0, plus its entry count.
  logic signed [VAL_W-1:0] shadow_list[DEPTH];
  int unsigned             held_count;
  // Results still owed by the block, oldest first.
  list_result_t            pending_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned full_hits;
  int unsigned badpos_hits;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Shadow list model
  // ---------------------------------------------------------------------

  function automatic void owe_result(status_t st, logic signed [VAL_W-1:0] v, logic lst);
    list_result_t r;
    r.status     = st;
    r.read_value = v;
    r.count_now  = CNT_W'(held_count);
    r.last       = lst;
    pending_results.push_back(r);
    if (st == ST_FULL) full_hits++;
    if (st == ST_BADPOS) badpos_hits++;
  endfunction

  // Open a slot at idx (0-based) by shifting the tail back by one.
  function automatic void shadow_insert(int unsigned idx, logic signed [VAL_W-1:0] v);
    for (int unsigned i = held_count; i > idx; i--)
      shadow_list[i] = shadow_list[i-1];
    shadow_list[idx] = v;
    held_count++;
  endfunction

  // Close the slot at idx (0-based) by pulling the tail forward.
  function automatic void shadow_remove(int unsigned idx);
    for (int unsigned i = idx; i + 1 < held_count; i++)
      shadow_list[i] = shadow_list[i+1];
    held_count--;
  endfunction

  // Apply one accepted request to the shadow list and queue what it owes.
  function automatic void apply_request(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] v,
                                        logic [POS_W-1:0] pos);
    status_t     st;
    int unsigned p;
    st = ST_OK;
    p  = pos;
    case (cmd)
      CMD_INS_FRONT: begin
        if (held_count >= DEPTH) st = ST_FULL;
        else shadow_insert(0, v);
      end
      CMD_INS_END: begin
        if (held_count >= DEPTH) st = ST_FULL;
        else shadow_insert(held_count, v);
      end
      CMD_INS_POS: begin
        // position range is checked ahead of fullness
        if (p < 1 || p > held_count + 1) st = ST_BADPOS;
        else if (held_count >= DEPTH) st = ST_FULL;
        else shadow_insert(p - 1, v);
      end
      CMD_DEL_FRONT: begin
        if (held_count == 0) st = ST_EMPTY;
        else shadow_remove(0);
      end
      CMD_DEL_END: begin
        if (held_count == 0) st = ST_EMPTY;
        else shadow_remove(held_count - 1);
      end
      CMD_DEL_POS: begin
        if (held_count == 0) st = ST_EMPTY;
        else if (p < 1 || p > held_count) st = ST_BADPOS;
        else shadow_remove(p - 1);
      end
      CMD_READ_ALL: begin
        if (held_count == 0) owe_result(ST_EMPTY, '0, 1'b1);
        else
          for (int unsigned i = 0; i < held_count; i++)
            owe_result(ST_OK, shadow_list[i], (i + 1 == held_count));
        return;
      end
      default: return;  // unused code: no result, no change
    endcase
    owe_result(st, '0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  function automatic void set_pacing(pacing_t pace);
    send_idle_pct  = (pace == PACE_SEND_IDLE)  ? 80 : (pace == PACE_BOTH) ? 12 : 0;
    recv_stall_pct = (pace == PACE_RECV_STALL) ? 80 : (pace == PACE_BOTH) ? 12 : 0;
  endfunction

  // Present one request and hold it until taken. Valid is left high on
  // return so back-to-back requests see no bubble; a gap, if drawn, drops
  // it at the start of the next call.
  task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] v,
                              logic [POS_W-1:0] pos);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_value    <= v;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    apply_request(cmd, v, pos);
    requests_sent++;
  endtask

  // Drop valid and let every owed result come back.
  task automatic settle_requests();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom();
    endcase
  endfunction

  // Mostly a legal 1..top position, with a share of zero, just-past-the-end
  // and wild values thrown in.
  function automatic logic [POS_W-1:0] pick_position(int unsigned top);
    int unsigned r;
    r = $urandom_range(99);
    if (top == 0 || r < 7) return POS_W'($urandom_range(255));
    if (r < 11) return POS_W'(top + 1);
    if (r < 13) return '0;
    if (r < 14) return '1;
    return POS_W'($urandom_range(top, 1));
  endfunction

  task automatic random_insert();
    case ($urandom_range(2))
      0:       send_request(CMD_INS_FRONT, pick_value(), POS_W'($urandom()));
      1:       send_request(CMD_INS_END, pick_value(), POS_W'($urandom()));
      default: send_request(CMD_INS_POS, pick_value(), POS_W'($urandom_range(held_count + 1, 1)));
    endcase
  endtask

  task automatic random_delete();
    case ($urandom_range(2))
      0:       send_request(CMD_DEL_FRONT, $urandom(), POS_W'($urandom()));
      1:       send_request(CMD_DEL_END, $urandom(), POS_W'($urandom()));
      default: send_request(CMD_DEL_POS, $urandom(),
                            POS_W'((held_count == 0) ? 1 : $urandom_range(held_count, 1)));
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reads, deletes and bad-position inserts against an empty list.
  task automatic test_empty_list();
    send_request(CMD_READ_ALL, '0, '0);
    send_request(CMD_DEL_FRONT, '0, '0);
    send_request(CMD_DEL_END, '0, '0);
    send_request(CMD_DEL_POS, '0, 8'd1);
    send_request(CMD_INS_POS, 32'sd5, 8'd2);  // past count+1
    send_request(CMD_INS_POS, 32'sd5, 8'd0);
  endtask

  // Inserts at each place with extreme values, then deletes around the
  // bounds until the only entry goes and the list reads empty again.
  task automatic test_edits_and_bounds();
    send_request(CMD_INS_POS, 32'sd17, 8'd1);
    send_request(CMD_INS_FRONT, 32'sh8000_0000, '0);
    send_request(CMD_INS_END, 32'sh7FFF_FFFF, '1);
    send_request(CMD_INS_POS, -32'sd1, 8'd2);
    send_request(CMD_INS_POS, 32'sd0, 8'd5);  // count+1 appends
    send_request(CMD_READ_ALL, '0, '0);
    send_request(CMD_DEL_POS, '0, 8'd0);
    send_request(CMD_DEL_POS, '0, 8'd6);      // one past count
    send_request(CMD_INS_POS, 32'sd9, 8'd7);  // two past count
    send_request(CMD_DEL_POS, '0, 8'd255);
    send_request(CMD_DEL_POS, '0, 8'd2);
    send_request(CMD_DEL_END, '0, '0);
    send_request(CMD_DEL_FRONT, '0, '0);
    send_request(CMD_DEL_END, '0, '0);
    send_request(CMD_DEL_POS, '0, 8'd1);      // only entry goes
    send_request(CMD_READ_ALL, '0, '0);
  endtask

  task automatic test_unused_code();
    send_request(CMD_UNUSED, 32'sh5A5A_A5A5, 8'hA5);
    send_request(CMD_UNUSED, 32'shA5A5_5A5A, 8'h5A);
    settle_requests();
  endtask

  // Fill to capacity, push past it (full, and bad position ahead of full),
  // then read the whole list.
  task automatic test_fill_and_overflow();
    while (held_count < DEPTH) random_insert();
    send_request(CMD_INS_FRONT, pick_value(), '0);
    send_request(CMD_INS_POS, pick_value(), POS_W'(DEPTH + 1));
    send_request(CMD_INS_POS, pick_value(), POS_W'($urandom_range(255, DEPTH + 2)));
    send_request(CMD_INS_END, pick_value(), '0);
    send_request(CMD_READ_ALL, '0, '0);
  endtask

  // Empty the list by random deletes, one more on empty, then read.
  task automatic test_drain_to_empty();
    while (held_count > 0) random_delete();
    random_delete();
    send_request(CMD_READ_ALL, '0, '0);
  endtask

  // Random mix of every request kind, bad positions and the unused code.
  task automatic test_random_mix(int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 14)      send_request(CMD_INS_FRONT, pick_value(), POS_W'($urandom()));
      else if (r < 28) send_request(CMD_INS_END, pick_value(), POS_W'($urandom()));
      else if (r < 42) send_request(CMD_INS_POS, pick_value(), pick_position(held_count + 1));
      else if (r < 54) send_request(CMD_DEL_FRONT, $urandom(), POS_W'($urandom()));
      else if (r < 66) send_request(CMD_DEL_END, $urandom(), POS_W'($urandom()));
      else if (r < 80) send_request(CMD_DEL_POS, $urandom(), pick_position(held_count));
      else if (r < 93) send_request(CMD_READ_ALL, $urandom(), POS_W'($urandom()));
      else             send_request(CMD_UNUSED, $urandom(), POS_W'($urandom()));
    end
  endtask

  // One pacing phase: random edits, a climb to full and a fall to empty.
  task automatic test_pacing_phase(pacing_t pace);
    set_pacing(pace);
    test_random_mix(24);
    test_fill_and_overflow();
    test_random_mix(16);
    test_drain_to_empty();
  endtask

  // ---------------------------------------------------------------------
  // Result side: pacing of out_ready and in-order field checks
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : result_check
    list_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("result with nothing owed: status %0d value %0d count %0d last %0d",
                 out_status, out_read_value, out_count_now, out_last);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (out_read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value, out_read_value);
            mismatches++;
          end
          if (out_count_now !== want.count_now) begin
            $error("count_now: expected %0d, got %0d", want.count_now, out_count_now);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_last);
            mismatches++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: any handshake on either channel counts as progress.
  always @(posedge clk) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no handshake for %0d cycles, %0d results still owed",
               quiet_cycles, pending_results.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_cmd      = CMD_INS_FRONT;
    in_value    = '0;
    in_position = '0;
    held_count  = 0;
    mismatches  = 0;
    set_pacing(PACE_FLOW);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_edits_and_bounds();
    test_unused_code();

    test_pacing_phase(PACE_FLOW);
    test_pacing_phase(PACE_SEND_IDLE);
    test_pacing_phase(PACE_RECV_STALL);
    test_pacing_phase(PACE_BOTH);
    set_pacing(PACE_FLOW);
    test_random_mix(20);

    settle_requests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Ran %0d requests, checked %0d results over four pacing phases.",
             requests_sent, results_checked);
    $display("Full rejections: %0d, bad-position rejections: %0d, mismatches: %0d.",
             full_hits, badpos_hits, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
